// ----- rtl/ppp_pkg.sv -----
`timescale 1ns / 1ps
package ppp_pkg;

  // Input point, signed Q16.16 world coordinates
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  // Projected result
  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               near_flag;
    logic               depth_error;
  } result_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_CAMERA_X = 3'd0,
    CFG_CAMERA_Y = 3'd1,
    CFG_CAMERA_Z = 3'd2,
    CFG_PITCH    = 3'd3,
    CFG_YAW      = 3'd4,
    CFG_ROLL     = 3'd5
  } cfg_reg_t;

  // Side information that travels along the depth divider
  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic               near;
    logic               neg;
    logic               shallow;
    logic               zero;
  } side_t;

  localparam int ANGLE_FULL = 16;
  localparam logic [31:0] RAD_STEP = 32'd411775;
  localparam logic signed [31:0] NEAR_LIMIT = 32'sd622592;
  localparam logic [32:0] PROJ_SCALE = 33'd300;
  localparam logic signed [47:0] PROJ_OFFSET_Q = 48'sd6553600;
  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  // Divider: quotient bits retired per stage
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = 32 / DIV_BITS;

  // Trig pipeline depth, rotation stages and total pipeline depth
  localparam int TRIG_STAGES = 9;
  localparam int ROT_STAGES  = 6;
  localparam int LATENCY     = TRIG_STAGES + ROT_STAGES + DIV_STAGES + 3;

endpackage

// ----- rtl/ppp_sincos.sv -----
`timescale 1ns / 1ps
module ppp_sincos import ppp_pkg::*; (
  input  logic               clk,
  input  logic [15:0]        angle,
  output logic signed [17:0] sin_q,
  output logic signed [17:0] cos_q
);

  localparam logic [32:0] ONE = 33'h1_0000_0000;
  localparam logic [63:0] R42 = ((64'd1 << 38) + 64'd41) / 64'd42;
  localparam logic [63:0] R56 = ((64'd1 << 38) + 64'd55) / 64'd56;
  localparam logic [63:0] R20 = ((64'd1 << 37) + 64'd19) / 64'd20;
  localparam logic [63:0] R30 = ((64'd1 << 37) + 64'd29) / 64'd30;
  localparam logic [63:0] R6  = ((64'd1 << 35) + 64'd5) / 64'd6;
  localparam logic [63:0] R12 = ((64'd1 << 36) + 64'd11) / 64'd12;

  // exact floor(v / d) through a reciprocal multiply
  function automatic logic [31:0] recip(input logic [31:0] v, input logic [63:0] m,
                                        input int k);
    logic [65:0] prod;
    prod = {34'd0, v} * {32'd0, m[33:0]};
    return 32'(prod >> k);
  endfunction

  function automatic logic [31:0] mul_hi(input logic [31:0] a, input logic [32:0] t);
    logic [64:0] prod;
    prod = {33'd0, a} * {32'd0, t};
    return prod[63:32];
  endfunction

  logic [13:0] r;
  logic        fold;
  logic [14:0] rr;
  logic [33:0] x_full;

  logic [31:0] s1_x;
  logic [31:0] xd  [2:7];
  logic [31:0] x2d [2:7];
  logic [1:0]  qd  [1:8];
  logic        fd  [1:8];
  logic [31:0] s3_a, s3_b, s4_a, s4_b, s5_a, s5_b, s6_a, s6_b, s7_a, s7_b, s8_a, s8_b;

  logic [32:0] c1;
  logic [16:0] ps, pc;
  logic signed [17:0] s0, c0, sin_next, cos_next;

  // fold to the first octant
  always_comb begin
    r      = angle[13:0];
    fold   = r > 14'd8192;
    rr     = fold ? (15'd16384 - {1'b0, r}) : {1'b0, r};
    x_full = {19'd0, rr} * {2'd0, RAD_STEP};
  end

  always_ff @(posedge clk) begin
    s1_x   <= x_full[31:0];
    qd[1]  <= angle[15:14];
    fd[1]  <= fold;
    xd[2]  <= s1_x;
    x2d[2] <= mul_hi(s1_x, {1'b0, s1_x});
    for (int i = 2; i <= 8; i++) begin
      qd[i] <= qd[i-1];
      fd[i] <= fd[i-1];
    end
    for (int i = 3; i <= 7; i++) begin
      xd[i]  <= xd[i-1];
      x2d[i] <= x2d[i-1];
    end
    s3_a <= recip(x2d[2], R42, 38);
    s3_b <= recip(x2d[2], R56, 38);
    s4_a <= mul_hi(x2d[3], ONE - {1'b0, s3_a});
    s4_b <= mul_hi(x2d[3], ONE - {1'b0, s3_b});
    s5_a <= recip(s4_a, R20, 37);
    s5_b <= recip(s4_b, R30, 37);
    s6_a <= mul_hi(x2d[5], ONE - {1'b0, s5_a});
    s6_b <= mul_hi(x2d[5], ONE - {1'b0, s5_b});
    s7_a <= recip(s6_a, R6, 35);
    s7_b <= recip(s6_b, R12, 36);
    s8_a <= mul_hi(xd[7], ONE - {1'b0, s7_a});
    s8_b <= mul_hi(x2d[7], ONE - {1'b0, s7_b});
    sin_q <= sin_next;
    cos_q <= cos_next;
  end

  // round to Q16, unfold octant and quadrant
  always_comb begin
    ps = 17'(({1'b0, s8_a} + 33'd32768) >> 16);
    c1 = ONE - {2'b0, s8_b[31:1]};
    pc = 17'(({1'b0, c1} + 34'd32768) >> 16);
    s0 = $signed({1'b0, fd[8] ? pc : ps});
    c0 = $signed({1'b0, fd[8] ? ps : pc});
    case (qd[8])
      2'd0: begin
        sin_next = s0;
        cos_next = c0;
      end
      2'd1: begin
        sin_next = c0;
        cos_next = -s0;
      end
      2'd2: begin
        sin_next = -s0;
        cos_next = -c0;
      end
      default: begin
        sin_next = -c0;
        cos_next = s0;
      end
    endcase
  end

endmodule

// ----- rtl/perspective_point_projection_core.sv -----
`timescale 1ns / 1ps
// Perspective projection of world points through an Euler-angle camera.
// Input channel: drive point and pulse start; a transfer happens at each
// rising edge with start high and busy low. busy is low outside reset, so
// one point can be taken in every cycle.
// Configuration: wr_en / wr_index / wr_data write camera_x, camera_y,
// camera_z (Q16.16) and pitch, yaw, roll angle codes (top ANGLE_BITS bits
// kept). Write only while no points are in flight.
// Output channel: done is high for one cycle with result holding
// screen_x, screen_y, near_flag and depth_error. The receiver takes every
// result; there is no back-pressure, so the pipeline never halts.
// Throughput is one point per cycle. The pipeline depth is set by the
// 9-stage sine/cosine pipeline, 6 rotation stages, the 16-stage divider
// (two quotient bits per stage) and 3 projection stages.
// Reset (synchronous, rst high) clears the camera registers and all valid
// bits; results already in flight are dropped.
module perspective_point_projection_core import ppp_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  point_t      point,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data,
  output logic        done,
  output result_t     result
);

  // rounded Q16 product: floor((coef * val + 0.5) )
  function automatic logic signed [39:0] mulq(input logic signed [17:0] coef,
                                              input logic signed [39:0] val);
    logic signed [57:0] prod;
    prod = coef * val;
    return 40'((prod + 58'sd32768) >>> 16);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'(SAT_MAX)) r = SAT_MAX;
    else if (v < 48'(SAT_MIN)) r = SAT_MIN;
    else r = v[31:0];
    return r;
  endfunction

  logic signed [31:0] camera_x, camera_y, camera_z;
  logic [ANGLE_BITS-1:0] pitch, yaw, roll;

  logic accept;
  logic [LATENCY-1:0] vpipe;

  logic signed [17:0] sx, cx, sy, cy, sz, cz;

  logic signed [32:0] offx [1:TRIG_STAGES];
  logic signed [32:0] offy [1:TRIG_STAGES];
  logic signed [32:0] offz [1:TRIG_STAGES];

  logic signed [39:0] r1_pa1, r1_pa2, r1_pb1, r1_pb2, r1_az;
  logic signed [39:0] r2_a, r2_b, r2_az;
  logic signed [39:0] r3_pc1, r3_pc2, r3_px1, r3_px2, r3_b;
  logic signed [39:0] r4_c, r4_b;
  logic signed [31:0] r4_dx;
  logic signed [39:0] r5_q1, r5_q2, r5_q3, r5_q4;
  logic signed [31:0] r5_dx;

  logic signed [31:0] dy_next, dz_next;
  logic [31:0]        den_next;
  side_t              side_next;
  logic [31:0]        r6_den;
  side_t              r6_side;

  logic [32:0] div_rem  [DIV_STAGES];
  logic [31:0] div_quo  [DIV_STAGES];
  logic [31:0] div_den  [DIV_STAGES];
  side_t       div_side [DIV_STAGES];

  logic [31:0]        quo;
  side_t              fin;
  logic               over;
  logic signed [31:0] k_next;
  logic               err_next;

  logic signed [31:0] p1_k;
  side_t              p1_side;
  logic               p1_err;
  logic signed [47:0] p2_x, p2_y;
  logic               p2_near, p2_err;

  assign busy   = rst;
  assign accept = start && !busy;
  assign done   = vpipe[LATENCY-1];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x <= '0;
      camera_y <= '0;
      camera_z <= '0;
      pitch    <= '0;
      yaw      <= '0;
      roll     <= '0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_CAMERA_X: camera_x <= wr_data;
        CFG_CAMERA_Y: camera_y <= wr_data;
        CFG_CAMERA_Z: camera_z <= wr_data;
        CFG_PITCH:    pitch    <= wr_data[15 -: ANGLE_BITS];
        CFG_YAW:      yaw      <= wr_data[15 -: ANGLE_BITS];
        CFG_ROLL:     roll     <= wr_data[15 -: ANGLE_BITS];
        default: ;
      endcase
    end
  end

  // Valid bits advance with the data every cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LATENCY-2:0], accept};
    end
  end

  // Sine and cosine run freely from the angle registers; their delay
  // matches the offset delay line so a point meets the angles it saw.
  ppp_sincos u_pitch (
    .clk   (clk),
    .angle (16'(pitch) << (ANGLE_FULL - ANGLE_BITS)),
    .sin_q (sx),
    .cos_q (cx)
  );

  ppp_sincos u_yaw (
    .clk   (clk),
    .angle (16'(yaw) << (ANGLE_FULL - ANGLE_BITS)),
    .sin_q (sy),
    .cos_q (cy)
  );

  ppp_sincos u_roll (
    .clk   (clk),
    .angle (16'(roll) << (ANGLE_FULL - ANGLE_BITS)),
    .sin_q (sz),
    .cos_q (cz)
  );

  // Camera-relative offsets, held in a delay line while the trig settles
  always_ff @(posedge clk) begin
    offx[1] <= 33'(point.point_x) - 33'(camera_x);
    offy[1] <= 33'(point.point_y) - 33'(camera_y);
    offz[1] <= 33'(point.point_z) - 33'(camera_z);
    for (int i = 2; i <= TRIG_STAGES; i++) begin
      offx[i] <= offx[i-1];
      offy[i] <= offy[i-1];
      offz[i] <= offz[i-1];
    end
  end

  // Rotation: roll, then yaw, then pitch; multiply and add stages alternate
  always_ff @(posedge clk) begin
    r1_pa1 <= mulq(sz, 40'(offy[TRIG_STAGES]));
    r1_pa2 <= mulq(cz, 40'(offx[TRIG_STAGES]));
    r1_pb1 <= mulq(cz, 40'(offy[TRIG_STAGES]));
    r1_pb2 <= mulq(sz, 40'(offx[TRIG_STAGES]));
    r1_az  <= 40'(offz[TRIG_STAGES]);

    r2_a  <= r1_pa1 + r1_pa2;
    r2_b  <= r1_pb1 - r1_pb2;
    r2_az <= r1_az;

    r3_pc1 <= mulq(cy, r2_az);
    r3_pc2 <= mulq(sy, r2_a);
    r3_px1 <= mulq(cy, r2_a);
    r3_px2 <= mulq(sy, r2_az);
    r3_b   <= r2_b;

    r4_c  <= r3_pc1 + r3_pc2;
    r4_dx <= sat32(48'(r3_px1 - r3_px2));
    r4_b  <= r3_b;

    r5_q1 <= mulq(sx, r4_c);
    r5_q2 <= mulq(cx, r4_b);
    r5_q3 <= mulq(cx, r4_c);
    r5_q4 <= mulq(sx, r4_b);
    r5_dx <= r4_dx;

    r6_den  <= den_next;
    r6_side <= side_next;
  end

  // Depth classification ahead of the divider
  always_comb begin
    dy_next  = sat32(48'(r5_q1 + r5_q2));
    dz_next  = sat32(48'(r5_q3 - r5_q4));
    den_next = dz_next[31] ? 32'(-dz_next) : 32'(dz_next);
    side_next.dx      = r5_dx;
    side_next.dy      = dy_next;
    side_next.near    = dz_next < NEAR_LIMIT;
    side_next.neg     = dz_next[31];
    side_next.zero    = dz_next == 32'sd0;
    side_next.shallow = den_next <= 32'(PROJ_SCALE);
  end

  // Restoring divider for 300 * 2^32 / |depth|. The numerator's low word
  // is zero, so each step only doubles the remainder. A depth of 300 or
  // less overflows and is flagged instead.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    logic [32:0] rem_in, rem_w, trial;
    logic [31:0] quo_in, quo_w, den_in;
    side_t       side_in;

    if (g == 0) begin : g_first
      assign rem_in  = PROJ_SCALE;
      assign quo_in  = '0;
      assign den_in  = r6_den;
      assign side_in = r6_side;
    end else begin : g_rest
      assign rem_in  = div_rem[g-1];
      assign quo_in  = div_quo[g-1];
      assign den_in  = div_den[g-1];
      assign side_in = div_side[g-1];
    end

    always_comb begin
      rem_w = rem_in;
      quo_w = quo_in;
      trial = '0;
      for (int b = 0; b < DIV_BITS; b++) begin
        trial = {rem_w[31:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          rem_w = trial - {1'b0, den_in};
          quo_w = {quo_w[30:0], 1'b1};
        end else begin
          rem_w = trial;
          quo_w = {quo_w[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      div_rem[g]  <= rem_w;
      div_quo[g]  <= quo_w;
      div_den[g]  <= den_in;
      div_side[g] <= side_in;
    end
  end

  // Signed quotient with clamping
  always_comb begin
    quo  = div_quo[DIV_STAGES-1];
    fin  = div_side[DIV_STAGES-1];
    over = fin.neg ? (quo[31] && (quo[30:0] != 31'd0)) : quo[31];
    if (fin.zero) begin
      k_next   = SAT_MAX;
      err_next = 1'b1;
    end else if (fin.shallow || over) begin
      k_next   = fin.neg ? SAT_MIN : SAT_MAX;
      err_next = 1'b1;
    end else begin
      k_next   = fin.neg ? -$signed(quo) : $signed(quo);
      err_next = 1'b0;
    end
  end

  // Projection: scale, round, offset and saturate
  always_ff @(posedge clk) begin
    p1_k    <= k_next;
    p1_err  <= err_next;
    p1_side <= fin;

    p2_x    <= 48'((64'(p1_k) * 64'(p1_side.dx) + 64'sd32768) >>> 16);
    p2_y    <= 48'((64'(p1_k) * 64'(p1_side.dy) + 64'sd32768) >>> 16);
    p2_near <= p1_side.near;
    p2_err  <= p1_err;

    result.screen_x    <= sat32(p2_x + PROJ_OFFSET_Q);
    result.screen_y    <= sat32(p2_y + PROJ_OFFSET_Q);
    result.near_flag   <= p2_near;
    result.depth_error <= p2_err;
  end

endmodule

// ----- rtl/ppp_checker.sv -----
`timescale 1ns / 1ps
module ppp_checker import ppp_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  // Outside reset a new point can always be taken
  a_no_busy: assert property (@(posedge clk) !rst |-> !busy)
    else $error("busy raised outside reset");

  // Reset flushes every result in flight
  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result after reset");

  // Every result comes from a matching earlier input transfer
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching input transfer");

  // Any divider clamp comes from a shallow or negative depth
  a_err_near: assert property (@(posedge clk) disable iff (rst)
    (done && result.depth_error) |-> result.near_flag)
    else $error("depth error on a far point");

endmodule

bind perspective_point_projection_core ppp_checker u_ppp_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
